// ===== hdl/bmpu_pkg.sv =====
// Shared types and constants for the BMP pixel row unpacker.
// Holds the register indexes, pixel mode codes and the pixel slot record.
// No dependencies.
package bmpu_pkg;

    // Default sizing of the top level.
    localparam int DEF_MAX_WIDTH       = 4096;
    localparam int DEF_MAX_HEIGHT      = 4096;
    localparam int DEF_PALETTE_ENTRIES = 256;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_MODE   = 2'd2;

    // Stream beat widths.
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;

    // Pixel formats.
    typedef enum logic [1:0] {
        MODE_PAL4 = 2'd0,
        MODE_PAL8 = 2'd1,
        MODE_BGR  = 2'd2,
        MODE_BGRA = 2'd3
    } pixel_mode_t;

    // One pixel on its way to the output: either a palette lookup or a
    // direct color, with its row and image markers.
    typedef struct packed {
        logic        use_pal;
        logic        black;
        logic [23:0] rgb;
        logic        row_end;
        logic        image_end;
    } pix_t;

endpackage

// ===== hdl/bmp_pixel_row_unpacker.sv =====
// BMP pixel row unpacker: turns pixel-data bytes and palette writes into RGB pixels.
// The palette lives in a synchronous single-port-read memory inside this module.
// Depends on bmpu_pkg.
//
// A pixel passes from its accepted byte through the palette read stage and the
// output register to m_tvalid. Throughput: one beat per cycle unless m_tready stalls
// the output; a 4-bpp byte that gives two pixels holds s_tready low while its second
// pixel waits for the one palette read port. Palette writes and pad bytes give no pixel.
// Reset (aresetn low, synchronous) clears all counters, the pipeline and sets width 1,
// height 1, 8-bpp mode; the palette is left as it is and is undefined until written.
module bmp_pixel_row_unpacker #(
    parameter int MAX_WIDTH       = bmpu_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = bmpu_pkg::DEF_MAX_HEIGHT,
    parameter int PALETTE_ENTRIES = bmpu_pkg::DEF_PALETTE_ENTRIES
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [bmpu_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bmpu_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // data_byte [7:0], palette_index [15:8], palette_color [39:16]
    input  logic [bmpu_pkg::S_DATA_W-1:0]     s_tdata,
    // action [0]
    input  logic                              s_tuser,

    // Pixel stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // red [7:0], green [15:8], blue [23:16]
    output logic [bmpu_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tlast,
    // image_end [0]
    output logic                              m_tuser
);

    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int RBW = $clog2(4 * MAX_WIDTH + 1);
    localparam int AW  = $clog2(PALETTE_ENTRIES);

    // Effective configuration.
    logic [CW-1:0]          w_reg, w_next;
    logic [RW-1:0]          h_reg, h_next;
    bmpu_pkg::pixel_mode_t  mode_reg, mode_next;
    logic [RBW-1:0]         db_reg, db_next;
    logic [RBW-1:0]         pad_reg, pad_next;

    // Stream position.
    logic [RBW-1:0]         rbc_reg, rbc_next;
    logic [CW-1:0]          col_reg, col_next;
    logic [RW-1:0]          row_reg, row_next;
    logic [23:0]            part_reg, part_next;
    logic [1:0]             bip_reg, bip_next;

    // Low-nibble pixel waiting for the read port.
    logic                   pend_valid_reg, pend_valid_next;
    bmpu_pkg::pix_t         pend_pix_reg, pend_pix_next;
    logic [AW-1:0]          pend_addr_reg, pend_addr_next;

    // Read issue, read stage and output register.
    logic                   iss_valid;
    bmpu_pkg::pix_t         iss_pix;
    logic [AW-1:0]          iss_addr;
    logic                   s1_valid_reg;
    bmpu_pkg::pix_t         s1_pix_reg;
    logic                   s1_adv;
    logic                   issue_ok;
    logic [23:0]            s1_rgb;
    logic                   m_valid_reg;
    logic [23:0]            m_data_reg;
    logic                   m_last_reg;
    logic                   m_user_reg;

    // Palette memory.
    logic [23:0]            pal_mem [PALETTE_ENTRIES];
    logic [23:0]            pal_rdata_reg;
    logic                   pal_we;
    logic                   pal_re;

    logic                   accept;
    logic                   is_pix;
    logic [7:0]             in_byte;
    logic [7:0]             in_index;
    logic [23:0]            in_color;

    assign accept   = s_tvalid && s_tready;
    assign is_pix   = s_tuser;
    assign in_byte  = s_tdata[7:0];
    assign in_index = s_tdata[15:8];
    assign in_color = s_tdata[39:16];

    // Handshake: the read stage moves on when the output register is free.
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign issue_ok = !s1_valid_reg || s1_adv;
    assign s_tready = !pend_valid_reg && issue_ok;

    // Configuration: clamp the written value and derive the row byte counts.
    always_comb begin
        logic [CW-1:0]  eff_w;
        logic [RW-1:0]  eff_h;
        logic [RBW+1:0] wx;
        logic [RBW+1:0] db_wide;
        logic [RBW+1:0] pad_wide;

        if (cfg_wdata == '0) begin
            eff_w = CW'(1);
        end else if (int'(cfg_wdata) > MAX_WIDTH) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(cfg_wdata);
        end
        if (cfg_wdata == '0) begin
            eff_h = RW'(1);
        end else if (int'(cfg_wdata) > MAX_HEIGHT) begin
            eff_h = RW'(MAX_HEIGHT);
        end else begin
            eff_h = RW'(cfg_wdata);
        end

        w_next    = w_reg;
        h_next    = h_reg;
        mode_next = mode_reg;
        if (cfg_we) begin
            case (cfg_addr)
                bmpu_pkg::CFG_IMAGE_WIDTH:  w_next = eff_w;
                bmpu_pkg::CFG_IMAGE_HEIGHT: h_next = eff_h;
                bmpu_pkg::CFG_PIXEL_MODE:   mode_next = bmpu_pkg::pixel_mode_t'(cfg_wdata[1:0]);
                default: ;
            endcase
        end

        wx = (RBW + 2)'(w_next);
        case (mode_next)
            bmpu_pkg::MODE_PAL4: db_wide = (wx + (RBW + 2)'(1)) >> 1;
            bmpu_pkg::MODE_PAL8: db_wide = wx;
            bmpu_pkg::MODE_BGR:  db_wide = wx + (wx << 1);
            default:             db_wide = wx << 2;
        endcase
        pad_wide      = db_wide + (RBW + 2)'(3);
        pad_wide[1:0] = 2'b00;
        db_next       = RBW'(db_wide);
        pad_next      = RBW'(pad_wide);
    end

    // Byte decode: counters, partial pixel and the palette read to issue.
    always_comb begin
        logic [CW:0]   col1;
        logic [CW:0]   col2;
        logic          last0;
        logic          last1;
        logic          row_last;
        logic [RBW:0]  rbc1;
        logic [23:0]   part_new;
        logic [1:0]    last_byte;

        rbc_next        = rbc_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        part_next       = part_reg;
        bip_next        = bip_reg;
        pend_valid_next = pend_valid_reg;
        pend_pix_next   = pend_pix_reg;
        pend_addr_next  = pend_addr_reg;
        iss_valid       = 1'b0;
        iss_pix         = '0;
        iss_addr        = '0;

        col1     = {1'b0, col_reg} + (CW + 1)'(1);
        col2     = col1 + (CW + 1)'(1);
        last0    = (col1 == {1'b0, w_reg});
        last1    = (col2 == {1'b0, w_reg});
        row_last = (({1'b0, row_reg} + (RW + 1)'(1)) == {1'b0, h_reg});
        rbc1     = {1'b0, rbc_reg} + (RBW + 1)'(1);
        last_byte = (mode_reg == bmpu_pkg::MODE_BGR) ? 2'd2 : 2'd3;

        part_new = part_reg;
        case (bip_reg)
            2'd0:    part_new[7:0]   = in_byte;
            2'd1:    part_new[15:8]  = in_byte;
            2'd2:    part_new[23:16] = in_byte;
            default: ;
        endcase

        // Second nibble of a 4-bpp byte goes out on the next free cycle.
        if (pend_valid_reg && issue_ok) begin
            iss_valid       = 1'b1;
            iss_pix         = pend_pix_reg;
            iss_addr        = pend_addr_reg;
            pend_valid_next = 1'b0;
        end

        if (accept && is_pix) begin
            if (rbc_reg < db_reg && col_reg < w_reg) begin
                case (mode_reg)
                    bmpu_pkg::MODE_PAL4: begin
                        iss_valid         = 1'b1;
                        iss_pix.use_pal   = 1'b1;
                        iss_pix.row_end   = last0;
                        iss_pix.image_end = last0 && row_last;
                        iss_addr          = AW'(in_byte[7:4]);
                        col_next          = CW'(col1);
                        if (!last0) begin
                            pend_valid_next         = 1'b1;
                            pend_pix_next           = '0;
                            pend_pix_next.use_pal   = 1'b1;
                            pend_pix_next.row_end   = last1;
                            pend_pix_next.image_end = last1 && row_last;
                            pend_addr_next          = AW'(in_byte[3:0]);
                            col_next                = CW'(col2);
                        end
                    end
                    bmpu_pkg::MODE_PAL8: begin
                        iss_valid         = 1'b1;
                        iss_pix.use_pal   = 1'b1;
                        iss_pix.black     = int'(in_byte) >= PALETTE_ENTRIES;
                        iss_pix.row_end   = last0;
                        iss_pix.image_end = last0 && row_last;
                        iss_addr          = in_byte[AW-1:0];
                        col_next          = CW'(col1);
                    end
                    default: begin
                        if (bip_reg >= last_byte) begin
                            iss_valid         = 1'b1;
                            iss_pix.rgb       = {part_new[7:0], part_new[15:8],
                                                 part_new[23:16]};
                            iss_pix.row_end   = last0;
                            iss_pix.image_end = last0 && row_last;
                            part_next         = '0;
                            bip_next          = '0;
                            col_next          = CW'(col1);
                        end else begin
                            part_next = part_new;
                            bip_next  = bip_reg + 2'd1;
                        end
                    end
                endcase
            end

            // End of the padded row starts the next row.
            if (rbc1 >= {1'b0, pad_reg}) begin
                rbc_next  = '0;
                col_next  = '0;
                part_next = '0;
                bip_next  = '0;
                row_next  = row_last ? '0 : RW'({1'b0, row_reg} + (RW + 1)'(1));
            end else begin
                rbc_next = RBW'(rbc1);
            end
        end

        // Any register write restarts the stream.
        if (cfg_we && (cfg_addr == bmpu_pkg::CFG_IMAGE_WIDTH ||
                       cfg_addr == bmpu_pkg::CFG_IMAGE_HEIGHT ||
                       cfg_addr == bmpu_pkg::CFG_PIXEL_MODE)) begin
            rbc_next  = '0;
            col_next  = '0;
            row_next  = '0;
            part_next = '0;
            bip_next  = '0;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg          <= CW'(1);
            h_reg          <= RW'(1);
            mode_reg       <= bmpu_pkg::MODE_PAL8;
            db_reg         <= RBW'(1);
            pad_reg        <= RBW'(4);
            rbc_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            part_reg       <= '0;
            bip_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            w_reg          <= w_next;
            h_reg          <= h_next;
            mode_reg       <= mode_next;
            db_reg         <= db_next;
            pad_reg        <= pad_next;
            rbc_reg        <= rbc_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            part_reg       <= part_next;
            bip_reg        <= bip_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Pending nibble payload.
    always_ff @(posedge aclk) begin
        pend_pix_reg  <= pend_pix_next;
        pend_addr_reg <= pend_addr_next;
    end

    // Palette memory: one write port, one registered read port.
    assign pal_we = accept && !is_pix && (int'(in_index) < PALETTE_ENTRIES);
    assign pal_re = iss_valid && iss_pix.use_pal && !iss_pix.black;

    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[in_index[AW-1:0]] <= in_color;
        end
        if (pal_re) begin
            pal_rdata_reg <= pal_mem[iss_addr];
        end
    end

    // Read stage: holds the slot while the output register is full and not being read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (issue_ok) begin
            s1_valid_reg <= iss_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue_ok && iss_valid) begin
            s1_pix_reg <= iss_pix;
        end
    end

    // Palette colors come as red 23:16; direct colors are already in beat order.
    always_comb begin
        if (!s1_pix_reg.use_pal) begin
            s1_rgb = s1_pix_reg.rgb;
        end else if (s1_pix_reg.black) begin
            s1_rgb = '0;
        end else begin
            s1_rgb = {pal_rdata_reg[7:0], pal_rdata_reg[15:8], pal_rdata_reg[23:16]};
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= s1_rgb;
            m_last_reg <= s1_pix_reg.row_end;
            m_user_reg <= s1_pix_reg.image_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule
